/* rtl/dgds_pkg.sv */
// shared types and constants of the diagonal gain solve block
package dgds_pkg;

  localparam int ANT_COUNT = 64;
  localparam int ANT_W     = $clog2(ANT_COUNT);
  localparam logic [6:0] ANT_LIMIT = 7'(ANT_COUNT);

  // quotient bits produced by each divider pass
  localparam int DIV_STEPS = 31;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] OPC_LOAD = 2'd0;
  localparam logic [1:0] OPC_VIS  = 2'd1;
  localparam logic [1:0] OPC_FIN  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  antenna_a;
    logic [5:0]  antenna_b;
    logic [63:0] data_xx;
    logic [63:0] data_xy;
    logic [63:0] data_yx;
    logic [63:0] data_yy;
    logic [63:0] model_xx;
    logic [63:0] model_xy;
    logic [63:0] model_yx;
    logic [63:0] model_yy;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  antenna_out;
    logic [63:0] gain_x_new;
    logic [63:0] gain_y_new;
    logic        x_invalid;
    logic        y_invalid;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [63:0] nx;
    logic [63:0] ny;
    logic [63:0] dx;
    logic [63:0] dy;
  } acc_row_t;

  // microsteps of one baseline side on the shared complex multiplier
  typedef enum logic [3:0] {
    ST_C0, ST_C1, ST_C2, ST_C3,
    ST_TX0, ST_TX1, ST_TY0, ST_TY1,
    ST_N0, ST_N1, ST_N2, ST_N3
  } step_t;

  typedef struct packed {
    logic       take;
    logic       gain_wr;
    logic       gain_rd;
    logic       gain_sel_b;
    logic       cap_ga;
    logic       cap_gb;
    logic       side;
    step_t      step;
    logic       wb;
    logic       acc_rd;
    logic       acc_fin;
    logic       acc_wr;
    logic       div_load;
    logic       div_step;
    logic       emit;
    logic       last;
    logic       clear;
    logic [5:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       a_ok;
    logic       b_ok;
  } dp_sts_t;

endpackage

/* rtl/dgds_ram.sv */
// generic single write port ram with registered read
module dgds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dgds_div.sv */
// restoring divider, one quotient bit per step, for one gain part
module dgds_div import dgds_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [31:0] numer,
  input  logic [63:0] denom,
  output logic [31:0] quot
);

  logic                 neg;
  logic                 sat;
  logic [63:0]          rem;
  logic [DIV_STEPS-1:0] q;
  logic [63:0]          d;
  logic [31:0]          mag;
  logic [63:0]          shifted;
  logic [64:0]          r2;

  assign mag     = numer[31] ? (~numer + 32'd1) : numer;
  assign shifted = {23'd0, mag, 9'd0};
  assign r2      = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= numer[31];
      sat <= (shifted >= denom);
      rem <= shifted;
      d   <= denom;
      q   <= '0;
    end else if (step) begin
      if (r2 >= {1'b0, d}) begin
        rem <= 64'(r2 - {1'b0, d});
        q   <= {q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= r2[63:0];
        q   <= {q[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (sat) begin
      quot = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg) begin
      quot = 32'(-{1'b0, q});
    end else begin
      quot = 32'({1'b0, q});
    end
  end

endmodule

/* rtl/dgds_dp.sv */
// datapath: gain and accumulator memories, complex multiplier, dividers
module dgds_dp import dgds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t result,
  output logic      result_valid
);

  localparam logic [63:0] DEN_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [39:0] SMAX = 40'sd2147483647;
  localparam logic signed [39:0] SMIN = -40'sd2147483648;

  function automatic logic signed [32:0] re33(logic [63:0] v);
    return $signed({v[63], v[63:32]});
  endfunction

  function automatic logic signed [32:0] im33(logic [63:0] v);
    return $signed({v[31], v[31:0]});
  endfunction

  function automatic logic [31:0] sat32(logic signed [39:0] v);
    if (v > SMAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < SMIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] numer_add(logic [63:0] acc, logic signed [39:0] tre,
                                            logic signed [39:0] tim);
    logic signed [39:0] sr;
    logic signed [39:0] si;
    sr = 40'($signed(acc[63:32])) + (tre >>> 12);
    si = 40'($signed(acc[31:0])) + (tim >>> 12);
    return {sat32(sr), sat32(si)};
  endfunction

  function automatic logic [63:0] denom_add(logic [63:0] acc, logic [36:0] t);
    logic [64:0] s;
    s = {1'b0, acc} + 65'(t);
    return (s > {1'b0, DEN_MAX}) ? DEN_MAX : s[63:0];
  endfunction

  in_item_t itm;
  logic [63:0] gax, gay, gbx, gby;
  logic [63:0] c [4];
  logic signed [39:0] tx_re, tx_im, ty_re, ty_im;
  logic [36:0] dx, dy;

  logic [ANT_W-1:0] a_addr, b_addr, side_addr, acc_raddr;
  logic [127:0] gain_rdata;
  acc_row_t acc_rdata, cur, row_new;
  logic [ANT_COUNT-1:0] acc_vld;
  logic vld_q;

  logic [63:0] opa, opb;
  logic conj_a, conj_b;
  logic signed [32:0] ar, ai, br, bi;
  logic signed [65:0] p0, p1, p2, p3;
  logic signed [37:0] s0, s1, s2, s3;
  logic signed [38:0] cre, cim;
  logic [35:0] nrm;

  logic [31:0] qxr, qxi, qyr, qyi;
  logic xi_q, yi_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      itm <= item;
    end
  end

  assign sts.op   = itm.opcode;
  assign sts.a_ok = {1'b0, itm.antenna_a} < ANT_LIMIT;
  assign sts.b_ok = {1'b0, itm.antenna_b} < ANT_LIMIT;

  assign a_addr    = itm.antenna_a[ANT_W-1:0];
  assign b_addr    = itm.antenna_b[ANT_W-1:0];
  assign side_addr = cmd.side ? b_addr : a_addr;
  assign acc_raddr = cmd.acc_fin ? cmd.k[ANT_W-1:0] : side_addr;

  dgds_ram #(.WIDTH(128), .DEPTH(ANT_COUNT)) u_gain (
    .clk   (clk),
    .we    (cmd.gain_wr),
    .waddr (a_addr),
    .wdata ({itm.data_xx, itm.data_yy}),
    .re    (cmd.gain_rd),
    .raddr (cmd.gain_sel_b ? b_addr : a_addr),
    .rdata (gain_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_ga) begin
      gax <= gain_rdata[127:64];
      gay <= gain_rdata[63:0];
    end
    if (cmd.cap_gb) begin
      gbx <= gain_rdata[127:64];
      gby <= gain_rdata[63:0];
    end
  end

  // side 0 updates antenna a from gain_b and conj model, side 1 antenna b
  always_comb begin
    opa    = c[0];
    opb    = c[0];
    conj_a = 1'b0;
    conj_b = 1'b0;
    unique case (cmd.step)
      ST_C0: begin
        opa = cmd.side ? gax : gbx; opb = itm.model_xx; conj_b = !cmd.side;
      end
      ST_C1: begin
        opa = cmd.side ? gax : gbx; opb = cmd.side ? itm.model_xy : itm.model_yx;
        conj_b = !cmd.side;
      end
      ST_C2: begin
        opa = cmd.side ? gay : gby; opb = cmd.side ? itm.model_yx : itm.model_xy;
        conj_b = !cmd.side;
      end
      ST_C3: begin
        opa = cmd.side ? gay : gby; opb = itm.model_yy; conj_b = !cmd.side;
      end
      ST_TX0: begin
        opa = itm.data_xx; opb = c[0]; conj_a = cmd.side;
      end
      ST_TX1: begin
        opa = cmd.side ? itm.data_yx : itm.data_xy; opb = c[2]; conj_a = cmd.side;
      end
      ST_TY0: begin
        opa = cmd.side ? itm.data_xy : itm.data_yx; opb = c[1]; conj_a = cmd.side;
      end
      ST_TY1: begin
        opa = itm.data_yy; opb = c[3]; conj_a = cmd.side;
      end
      ST_N0: begin opa = c[0]; opb = c[0]; end
      ST_N1: begin opa = c[1]; opb = c[1]; end
      ST_N2: begin opa = c[2]; opb = c[2]; end
      ST_N3: begin opa = c[3]; opb = c[3]; end
      default: begin opa = c[0]; opb = c[0]; end
    endcase
  end

  assign ar = re33(opa);
  assign ai = conj_a ? -im33(opa) : im33(opa);
  assign br = re33(opb);
  assign bi = conj_b ? -im33(opb) : im33(opb);

  always_ff @(posedge clk) begin
    p0 <= ar * br;
    p1 <= ai * bi;
    p2 <= ar * bi;
    p3 <= ai * br;
  end

  // each partial product floored to q.28
  assign s0  = $signed(p0[65:28]);
  assign s1  = $signed(p1[65:28]);
  assign s2  = $signed(p2[65:28]);
  assign s3  = $signed(p3[65:28]);
  assign cre = 39'(s0) - 39'(s1);
  assign cim = 39'(s2) + 39'(s3);
  assign nrm = s0[35:0] + s1[35:0];

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      unique case (cmd.step)
        ST_C0:  c[0] <= {sat32(40'(cre)), sat32(40'(cim))};
        ST_C1:  c[1] <= {sat32(40'(cre)), sat32(40'(cim))};
        ST_C2:  c[2] <= {sat32(40'(cre)), sat32(40'(cim))};
        ST_C3:  c[3] <= {sat32(40'(cre)), sat32(40'(cim))};
        ST_TX0: begin tx_re <= 40'(cre); tx_im <= 40'(cim); end
        ST_TX1: begin tx_re <= tx_re + 40'(cre); tx_im <= tx_im + 40'(cim); end
        ST_TY0: begin ty_re <= 40'(cre); ty_im <= 40'(cim); end
        ST_TY1: begin ty_re <= ty_re + 40'(cre); ty_im <= ty_im + 40'(cim); end
        ST_N0:  dx <= 37'(nrm);
        ST_N1:  dy <= 37'(nrm);
        ST_N2:  dx <= dx + 37'(nrm);
        ST_N3:  dy <= dy + 37'(nrm);
        default: dx <= dx;
      endcase
    end
  end

  dgds_ram #(.WIDTH($bits(acc_row_t)), .DEPTH(ANT_COUNT)) u_acc (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (side_addr),
    .wdata (row_new),
    .re    (cmd.acc_rd),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // rows not written since the last finish read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (cmd.acc_rd) begin
        vld_q <= acc_vld[acc_raddr];
      end
      if (cmd.clear) begin
        acc_vld <= '0;
      end else if (cmd.acc_wr) begin
        acc_vld[side_addr] <= 1'b1;
      end
    end
  end

  assign cur = vld_q ? acc_rdata : '0;

  always_comb begin
    row_new.nx = numer_add(cur.nx, tx_re, tx_im);
    row_new.ny = numer_add(cur.ny, ty_re, ty_im);
    row_new.dx = denom_add(cur.dx, dx);
    row_new.dy = denom_add(cur.dy, dy);
  end

  dgds_div u_div_xr (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                     .numer(cur.nx[63:32]), .denom(cur.dx), .quot(qxr));
  dgds_div u_div_xi (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                     .numer(cur.nx[31:0]), .denom(cur.dx), .quot(qxi));
  dgds_div u_div_yr (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                     .numer(cur.ny[63:32]), .denom(cur.dy), .quot(qyr));
  dgds_div u_div_yi (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                     .numer(cur.ny[31:0]), .denom(cur.dy), .quot(qyi));

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      xi_q <= (cur.dx == '0);
      yi_q <= (cur.dy == '0);
    end
    if (cmd.emit) begin
      result.antenna_out <= cmd.k;
      result.gain_x_new  <= xi_q ? 64'd0 : {qxr, qxi};
      result.gain_y_new  <= yi_q ? 64'd0 : {qyr, qyi};
      result.x_invalid   <= xi_q;
      result.y_invalid   <= yi_q;
      result.last_out    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

endmodule

/* rtl/dgds_ctrl.sv */
// controller: item decode, multiplier microsteps and finish sequencing
module dgds_ctrl import dgds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_GRD_A, S_GRD_B, S_GCAP_B, S_MUL, S_WB,
    S_ACC_RD, S_ACC_WR, S_FIN_RD, S_FIN_LD, S_FIN_DIV, S_FIN_OUT, S_FIN_CLR
  } state_t;

  state_t state;
  step_t step;
  logic side;
  logic [6:0] k;
  logic [DCNT_W-1:0] dcnt;
  logic [6:0] antennas_in_use;
  logic [6:0] cnt;
  logic last_k;

  assign cnt    = (antennas_in_use > ANT_LIMIT) ? ANT_LIMIT : antennas_in_use;
  assign last_k = (k + 7'd1) == cnt;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= ST_C0;
      side            <= 1'b0;
      k               <= '0;
      dcnt            <= '0;
      antennas_in_use <= 7'd64;
    end else begin
      if (cfg_wr_en) begin
        antennas_in_use <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_DECODE;
        end
        S_DECODE: begin
          priority case (sts.op)
            OPC_VIS: state <= (sts.a_ok && sts.b_ok) ? S_GRD_A : S_IDLE;
            OPC_FIN: begin
              k     <= '0;
              state <= (cnt == '0) ? S_FIN_CLR : S_FIN_RD;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_GRD_A: state <= S_GRD_B;
        S_GRD_B: state <= S_GCAP_B;
        S_GCAP_B: begin
          side  <= 1'b0;
          step  <= ST_C0;
          state <= S_MUL;
        end
        S_MUL: state <= S_WB;
        S_WB: begin
          if (step == ST_N3) begin
            state <= S_ACC_RD;
          end else begin
            step  <= step_t'(step + 4'd1);
            state <= S_MUL;
          end
        end
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: begin
          if (!side) begin
            side  <= 1'b1;
            step  <= ST_C0;
            state <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN_RD: state <= S_FIN_LD;
        S_FIN_LD: begin
          dcnt  <= '0;
          state <= S_FIN_DIV;
        end
        S_FIN_DIV: begin
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (last_k) begin
            state <= S_FIN_CLR;
          end else begin
            k     <= k + 7'd1;
            state <= S_FIN_RD;
          end
        end
        S_FIN_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.side = side;
    cmd.step = step;
    cmd.k    = k[5:0];
    unique case (state)
      S_IDLE:    cmd.take = start;
      S_DECODE:  cmd.gain_wr = (sts.op == OPC_LOAD) && sts.a_ok;
      S_GRD_A:   cmd.gain_rd = 1'b1;
      S_GRD_B: begin
        cmd.cap_ga     = 1'b1;
        cmd.gain_rd    = 1'b1;
        cmd.gain_sel_b = 1'b1;
      end
      S_GCAP_B:  cmd.cap_gb = 1'b1;
      S_MUL:     cmd.wb = 1'b0;
      S_WB:      cmd.wb = 1'b1;
      S_ACC_RD:  cmd.acc_rd = 1'b1;
      S_ACC_WR:  cmd.acc_wr = 1'b1;
      S_FIN_RD: begin
        cmd.acc_rd  = 1'b1;
        cmd.acc_fin = 1'b1;
      end
      S_FIN_LD:  cmd.div_load = 1'b1;
      S_FIN_DIV: cmd.div_step = 1'b1;
      S_FIN_OUT: begin
        cmd.emit = 1'b1;
        cmd.last = last_k;
      end
      S_FIN_CLR: cmd.clear = 1'b1;
      default:   cmd.take = 1'b0;
    endcase
  end

endmodule

/* rtl/diagonal_gain_direction_solve.sv */
// top level: one direction's diagonal gain update, controller plus datapath
// load item, opcode 3 or out-of-range antenna: handled in the decode state, then idle
// visibility item: gain reads, then per antenna 12 multiplier steps, each a multiply
// state and a write-back state, then an accumulator read and write
// finish item: per antenna an accumulator read, a divider load, the 31-step divider, an emit
// results appear in the cycle after their emit step, strobed for one cycle, never stalled
// synchronous reset clears control, accumulator valid bits and sets antennas_in_use to 64
module diagonal_gain_direction_solve import dgds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   item,
  output out_item_t  result,
  output logic       result_valid,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dgds_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  dgds_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

/* rtl/dgds_chk.sv */
// port level checks of the diagonal gain solve block, bound to the top level
module dgds_chk import dgds_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input out_item_t result,
  input logic      result_valid
);

  // an accepted item keeps the block busy on the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // results come only out of a finish in progress
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe while idle");

  // result strobes never come back to back; every result waits on a full divider pass
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobes back to back");

  // the last result of a run ends the finish
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_out) |=> !busy)
    else $error("block still busy after last result");

endmodule

bind diagonal_gain_direction_solve dgds_chk u_chk (.*);
